// ===== hdl/vglm_pkg.sv =====
// Shared types and constants for the voice gain, low-pass and mix block.
package vglm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int ALPHA_W  = 16;
  localparam int SCALED_W = 33;  // sample * gain, exact
  localparam int STATE_W  = 34;  // filter state per voice
  localparam int MIX_W    = 40;  // frame accumulators
  localparam int VOICE_W  = 4;

  // Default configuration of the block
  localparam int DEF_VOICES = 16;
  localparam int CMD_DEPTH  = 2;
  localparam int RES_DEPTH  = 2;

  // Coefficient at or above this value bypasses the filter
  localparam logic [ALPHA_W-1:0] BYPASS_ALPHA = 16'd32736;

  // Configuration register indexes and reset values
  localparam logic REG_OUTPUT_GAIN = 1'b0;
  localparam logic [GAIN_W-1:0] OUT_GAIN_RESET = 16'd4096;

  // Accumulator limits
  localparam logic signed [MIX_W-1:0] MIX_MAX = {1'b0, {(MIX_W-1){1'b1}}};
  localparam logic signed [MIX_W-1:0] MIX_MIN = {1'b1, {(MIX_W-1){1'b0}}};

  // One classified and scaled voice item, front to back
  typedef struct packed {
    logic [VOICE_W-1:0]         voice;
    logic                       touch;      // voice in range, state is written
    logic                       clear;      // start from a cleared state
    logic                       mix_en;     // filter output goes into the mix
    logic                       bypass;
    logic [ALPHA_W-1:0]         alpha;
    logic signed [SCALED_W-1:0] xl;
    logic signed [SCALED_W-1:0] xr;
    logic                       frame_end;
  } cmd_t;

  // One finished output frame
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       clipped;
  } res_t;

endpackage

// ===== hdl/vglm_fifo.sv =====
// Small first-in first-out queue used between the block's parts.
module vglm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Store incoming transfer
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - CNT_W'(1)))
    else $error("queue pop did not lower occupancy");

endmodule

// ===== hdl/vglm_front.sv =====
// Front end: accepts voice items, classifies them and scales samples by gain.
module vglm_front #(
  parameter int VOICES = vglm_pkg::DEF_VOICES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [vglm_pkg::VOICE_W-1:0]         voice,
  input  logic signed [vglm_pkg::SAMPLE_W-1:0] sample_left,
  input  logic signed [vglm_pkg::SAMPLE_W-1:0] sample_right,
  input  logic [vglm_pkg::GAIN_W-1:0]          gain_left,
  input  logic [vglm_pkg::GAIN_W-1:0]          gain_right,
  input  logic [vglm_pkg::ALPHA_W-1:0]         alpha,
  input  logic                                 restart,
  input  logic                                 skip,
  input  logic                                 frame_end,
  output logic                                 cmd_push,
  output vglm_pkg::cmd_t                       cmd,
  input  logic                                 cmd_full
);
  import vglm_pkg::*;

  localparam logic [8:0] VOICES_L = 9'(VOICES);

  logic stage_valid;
  logic accept;
  logic in_range;
  cmd_t cmd_in;

  assign full     = stage_valid && cmd_full;
  assign accept   = push && !full;
  assign cmd_push = stage_valid;
  assign in_range = ({5'd0, voice} < VOICES_L);

  // Classify the item and scale both channels
  always_comb begin
    cmd_in.voice     = voice;
    cmd_in.touch     = in_range && (restart || !skip);
    cmd_in.clear     = restart;
    cmd_in.mix_en    = in_range && !skip;
    cmd_in.bypass    = (alpha >= BYPASS_ALPHA);
    cmd_in.alpha     = alpha;
    cmd_in.xl        = sample_left * $signed({1'b0, gain_left});
    cmd_in.xr        = sample_right * $signed({1'b0, gain_right});
    cmd_in.frame_end = frame_end;
  end

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (!cmd_full) begin
      stage_valid <= 1'b0;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && cmd_full) |=> (stage_valid && $stable(cmd)))
    else $error("stalled front item was lost or changed");

endmodule

// ===== hdl/vglm_back.sv =====
// Back end: per-voice low-pass filter, frame mix and output gain with clipping.
module vglm_back #(
  parameter int VOICES = vglm_pkg::DEF_VOICES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [vglm_pkg::GAIN_W-1:0]  output_gain,
  input  vglm_pkg::cmd_t               cmd_head,
  input  logic                         cmd_empty,
  output logic                         cmd_pop,
  output logic                         res_push,
  output vglm_pkg::res_t               res,
  input  logic                         res_full
);
  import vglm_pkg::*;

  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int PA_W  = SCALED_W + 17;
  localparam int PB_W  = STATE_W + 18;
  localparam int SUM_W = PB_W + 1;
  localparam int P_W   = MIX_W + 17;

  localparam logic signed [P_W-1:0] P_HI = 57'sd2198956146688;   // 32767 * 2^26
  localparam logic signed [P_W-1:0] P_LO = -57'sd2199023255552;  // -32768 * 2^26
  localparam logic signed [P_W-1:0] P_BIAS = 57'sd67108863;      // 2^26 - 1

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_FILT = 3'd2;
  localparam logic [2:0] B_MIX  = 3'd3;
  localparam logic [2:0] B_GAIN = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  cmd_t cur;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] head_addr;

  logic signed [STATE_W-1:0] mem_l [VOICES];
  logic signed [STATE_W-1:0] mem_r [VOICES];
  logic [VOICES-1:0]         valid;
  logic signed [STATE_W-1:0] rd_l;
  logic signed [STATE_W-1:0] rd_r;
  logic                      rd_ok;

  logic signed [STATE_W-1:0] prev_l;
  logic signed [STATE_W-1:0] prev_r;
  logic [16:0]               coef_a;
  logic [16:0]               coef_b;
  logic signed [PA_W-1:0]    pa_l;
  logic signed [PA_W-1:0]    pa_r;
  logic signed [PB_W-1:0]    pb_l;
  logic signed [PB_W-1:0]    pb_r;
  logic signed [SUM_W-1:0]   sum_l;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [STATE_W-1:0] y_next_l;
  logic signed [STATE_W-1:0] y_next_r;
  logic signed [STATE_W-1:0] y_l;
  logic signed [STATE_W-1:0] y_r;

  logic signed [MIX_W-1:0]   mix_l;
  logic signed [MIX_W-1:0]   mix_r;
  logic signed [MIX_W-1:0]   mix_next_l;
  logic signed [MIX_W-1:0]   mix_next_r;
  logic signed [P_W-1:0]     p_l;
  logic signed [P_W-1:0]     p_r;
  logic [SAMPLE_W:0]         fin_l;
  logic [SAMPLE_W:0]         fin_r;

  // Saturating accumulate into a frame sum
  function automatic logic signed [MIX_W-1:0] sat_add(
    input logic signed [MIX_W-1:0]   acc,
    input logic signed [STATE_W-1:0] v
  );
    logic signed [MIX_W:0] s;
    s = (MIX_W + 1)'(acc) + (MIX_W + 1)'(v);
    if (s > (MIX_W + 1)'(MIX_MAX)) begin
      return MIX_MAX;
    end else if (s < (MIX_W + 1)'(MIX_MIN)) begin
      return MIX_MIN;
    end else begin
      return MIX_W'(s);
    end
  endfunction

  // Scale back by 2^26 toward zero and clamp; top bit flags clipping
  function automatic logic [SAMPLE_W:0] finish(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] t;
    t = p + (p[P_W-1] ? P_BIAS : '0);
    if (p > P_HI) begin
      return {1'b1, 16'h7fff};
    end else if (p < P_LO) begin
      return {1'b1, 16'h8000};
    end else begin
      return {1'b0, SAMPLE_W'(t >>> 26)};
    end
  endfunction

  assign head_addr = AW'(cmd_head.voice);
  assign cmd_pop   = (state == B_IDLE) && !cmd_empty;
  assign res_push  = (state == B_OUT) && !res_full;

  // Sequence one item at a time
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!cmd_empty) begin
        state_next = B_MUL;
      end
      B_MUL:  state_next = B_FILT;
      B_FILT: state_next = B_MIX;
      B_MIX:  state_next = cur.frame_end ? B_GAIN : B_IDLE;
      B_GAIN: state_next = B_OUT;
      B_OUT: if (!res_full) begin
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take the item and read its voice state
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur      <= cmd_head;
      cur_addr <= head_addr;
      rd_l     <= mem_l[head_addr];
      rd_r     <= mem_r[head_addr];
      rd_ok    <= valid[head_addr] && !cmd_head.clear;
    end
  end

  // Form both filter products
  assign prev_l = rd_ok ? rd_l : '0;
  assign prev_r = rd_ok ? rd_r : '0;
  assign coef_a = {1'b0, cur.alpha};
  assign coef_b = 17'd32768 - coef_a;

  always_ff @(posedge clk) begin
    if (state == B_MUL) begin
      pa_l <= $signed(coef_a) * cur.xl;
      pa_r <= $signed(coef_a) * cur.xr;
      pb_l <= $signed({1'b0, coef_b}) * prev_l;
      pb_r <= $signed({1'b0, coef_b}) * prev_r;
    end
  end

  // Round half up and drop 15 fraction bits, pass the scaled sample, or give zero when not mixed
  assign sum_l = SUM_W'(pa_l) + SUM_W'(pb_l) + SUM_W'(16384);
  assign sum_r = SUM_W'(pa_r) + SUM_W'(pb_r) + SUM_W'(16384);

  always_comb begin
    if (!cur.mix_en) begin
      y_next_l = '0;
      y_next_r = '0;
    end else if (cur.bypass) begin
      y_next_l = STATE_W'(cur.xl);
      y_next_r = STATE_W'(cur.xr);
    end else begin
      y_next_l = STATE_W'(sum_l >>> 15);
      y_next_r = STATE_W'(sum_r >>> 15);
    end
  end

  // Write back the voice state
  always_ff @(posedge clk) begin
    if (state == B_FILT) begin
      y_l <= y_next_l;
      y_r <= y_next_r;
      if (cur.touch) begin
        mem_l[cur_addr] <= y_next_l;
        mem_r[cur_addr] <= y_next_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if ((state == B_FILT) && cur.touch) begin
      valid[cur_addr] <= 1'b1;
    end
  end

  // Accumulate the frame, then clear it once the gain product is taken
  assign mix_next_l = sat_add(mix_l, y_l);
  assign mix_next_r = sat_add(mix_r, y_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_l <= '0;
      mix_r <= '0;
    end else if ((state == B_MIX) && cur.mix_en) begin
      mix_l <= mix_next_l;
      mix_r <= mix_next_r;
    end else if (state == B_GAIN) begin
      mix_l <= '0;
      mix_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_GAIN) begin
      p_l <= mix_l * $signed({1'b0, output_gain});
      p_r <= mix_r * $signed({1'b0, output_gain});
    end
  end

  // Saturate and hand over the frame
  assign fin_l         = finish(p_l);
  assign fin_r         = finish(p_r);
  assign res.out_left  = fin_l[SAMPLE_W-1:0];
  assign res.out_right = fin_r[SAMPLE_W-1:0];
  assign res.clipped   = fin_l[SAMPLE_W] | fin_r[SAMPLE_W];

  a_mix_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == B_GAIN) |=> ((mix_l == '0) && (mix_r == '0)))
    else $error("frame sums not cleared after frame end");

  a_state_written: assert property (@(posedge clk) disable iff (rst)
    ((state == B_FILT) && cur.touch) |=> valid[cur_addr])
    else $error("voice state written but not marked valid");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state == B_MUL))
    else $error("item taken without starting the filter sequence");

endmodule

// ===== hdl/voice_gain_lowpass_mixer.sv =====
// Top level of the multi-voice mixer with per-voice gain and one-pole low-pass.
//
// Each transfer on the input queue is one stereo sample of one voice; the
// front end scales it by the voice gains in the cycle it is taken and places
// it in a two-entry command queue. The back end works one item at a time,
// in steps: state read, filter products, rounding and state write, and
// saturating accumulate; an item that ends a frame adds the output gain
// product, then saturation into the result queue, which holds the back
// end while it is full. That sequencer sets the sustained rate.
// Filter state lives in a memory of VOICES entries with one valid bit each,
// so reset needs no clearing pass. output_gain is at byte address 0 and
// should be written only while the block is idle.
module voice_gain_lowpass_mixer #(
  parameter int VOICES = vglm_pkg::DEF_VOICES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // voice items
  input  logic                                 push,
  output logic                                 full,
  input  logic [vglm_pkg::VOICE_W-1:0]         voice,
  input  logic signed [vglm_pkg::SAMPLE_W-1:0] sample_left,
  input  logic signed [vglm_pkg::SAMPLE_W-1:0] sample_right,
  input  logic [vglm_pkg::GAIN_W-1:0]          gain_left,
  input  logic [vglm_pkg::GAIN_W-1:0]          gain_right,
  input  logic [vglm_pkg::ALPHA_W-1:0]         alpha,
  input  logic                                 restart,
  input  logic                                 skip,
  input  logic                                 frame_end,
  // mixed frames
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [vglm_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [vglm_pkg::SAMPLE_W-1:0] out_right,
  output logic                                 clipped,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import vglm_pkg::*;

  logic [GAIN_W-1:0] output_gain;
  logic              cfg_write;

  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_in;
  cmd_t cmd_head;

  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_head;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_gain <= OUT_GAIN_RESET;
    end else if (cfg_write && (paddr[2] == REG_OUTPUT_GAIN)) begin
      output_gain <= pwdata[GAIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OUTPUT_GAIN) begin
      prdata = {{(32 - GAIN_W){1'b0}}, output_gain};
    end
  end

  vglm_front #(
    .VOICES (VOICES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .voice        (voice),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .gain_left    (gain_left),
    .gain_right   (gain_right),
    .alpha        (alpha),
    .restart      (restart),
    .skip         (skip),
    .frame_end    (frame_end),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .cmd_full     (cmd_full)
  );

  vglm_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  vglm_back #(
    .VOICES (VOICES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .output_gain (output_gain),
    .cmd_head    (cmd_head),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .res_push    (res_push),
    .res         (res_in),
    .res_full    (res_full)
  );

  vglm_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  // Oldest finished frame on the result ports
  assign out_left  = res_head.out_left;
  assign out_right = res_head.out_right;
  assign clipped   = res_head.clipped;

endmodule

// ===== test/mixer_checker.sv =====
// Frame checker for the voice mixer: tracks filter and mix state, predicts and compares frames.
module mixer_checker
  import vglm_pkg::*;
#(
  parameter int VOICES = DEF_VOICES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       full,
  input  logic [VOICE_W-1:0]         voice,
  input  logic signed [SAMPLE_W-1:0] sample_left,
  input  logic signed [SAMPLE_W-1:0] sample_right,
  input  logic [GAIN_W-1:0]          gain_left,
  input  logic [GAIN_W-1:0]          gain_right,
  input  logic [ALPHA_W-1:0]         alpha,
  input  logic                       restart,
  input  logic                       skip,
  input  logic                       frame_end,
  input  logic                       empty,
  input  logic                       pop,
  input  logic signed [SAMPLE_W-1:0] out_left,
  input  logic signed [SAMPLE_W-1:0] out_right,
  input  logic                       clipped,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int                         errors,
  output int                         pending,
  output int                         frames_seen,
  output int                         clips_seen
);

  localparam logic [2:0] GAIN_ADDR = 3'(4 * int'(REG_OUTPUT_GAIN));
  localparam longint OUT_HI = 64'sd32767 * 64'sd67108864;
  localparam longint OUT_LO = -64'sd32768 * 64'sd67108864;

  logic [GAIN_W-1:0]         out_gain;
  logic signed [STATE_W-1:0] lp_left [VOICES];
  logic signed [STATE_W-1:0] lp_right [VOICES];
  logic signed [MIX_W-1:0]   sum_left;
  logic signed [MIX_W-1:0]   sum_right;
  res_t                      frames_due [$];

  initial begin
    errors = 0;
    pending = 0;
    frames_seen = 0;
    clips_seen = 0;
  end

  // One-pole step, rounded half up, floor on the shift
  function automatic longint smooth(longint x, longint prev, longint a);
    longint acc;
    acc = a * x + (64'sd32768 - a) * prev + 64'sd16384;
    return acc >>> 15;
  endfunction

  // Add into a frame sum, hold at the 40-bit limits
  function automatic logic signed [MIX_W-1:0] accum(logic signed [MIX_W-1:0] s, longint v);
    longint t;
    t = longint'(s) + v;
    if (t > longint'(MIX_MAX)) return MIX_MAX;
    if (t < longint'(MIX_MIN)) return MIX_MIN;
    return t[MIX_W-1:0];
  endfunction

  // Apply output gain, truncate toward zero, saturate to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] scale_out(logic signed [MIX_W-1:0] m,
                                                          logic [GAIN_W-1:0] g,
                                                          output bit sat);
    longint p;
    longint q;
    p = longint'(m) * longint'(g);
    sat = 1'b0;
    if (p > OUT_HI) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (p < OUT_LO) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    q = (p >= 0) ? (p >>> 26) : -((-p) >>> 26);
    return q[SAMPLE_W-1:0];
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Advance the mixer state by one accepted voice item
  task automatic take_item();
    longint xl;
    longint xr;
    longint yl;
    longint yr;
    bit     sat_l;
    bit     sat_r;
    res_t   r;
    if (int'(voice) < VOICES) begin
      if (restart) begin
        lp_left[voice] = '0;
        lp_right[voice] = '0;
      end
      if (!skip) begin
        xl = longint'(sample_left) * longint'(gain_left);
        xr = longint'(sample_right) * longint'(gain_right);
        if (alpha < BYPASS_ALPHA) begin
          yl = smooth(xl, longint'(lp_left[voice]), longint'(alpha));
          yr = smooth(xr, longint'(lp_right[voice]), longint'(alpha));
        end else begin
          yl = xl;
          yr = xr;
        end
        lp_left[voice] = yl[STATE_W-1:0];
        lp_right[voice] = yr[STATE_W-1:0];
        sum_left = accum(sum_left, yl);
        sum_right = accum(sum_right, yr);
      end
    end
    if (frame_end) begin
      r.out_left = scale_out(sum_left, out_gain, sat_l);
      r.out_right = scale_out(sum_right, out_gain, sat_r);
      r.clipped = sat_l | sat_r;
      frames_due.insert(frames_due.size(), r);
      sum_left = '0;
      sum_right = '0;
    end
  endtask

  // Watch all channels at each rising edge
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_gain = OUT_GAIN_RESET;
      for (int i = 0; i < VOICES; i++) begin
        lp_left[i] = '0;
        lp_right[i] = '0;
      end
      sum_left = '0;
      sum_right = '0;
      frames_due.delete();
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite && paddr == GAIN_ADDR)
          out_gain = pwdata[GAIN_W-1:0];
        if (!pwrite && paddr == GAIN_ADDR && prdata !== {16'd0, out_gain})
          report("output_gain readback", prdata, out_gain);
      end
      // frame transfer out
      if (pop && !empty) begin
        if (frames_due.size() == 0) begin
          report("frame with nothing expected, out_left", out_left, 0);
        end else begin
          want = frames_due.pop_front();
          frames_seen++;
          if (want.clipped) clips_seen++;
          if (out_left !== want.out_left) report("out_left", out_left, want.out_left);
          if (out_right !== want.out_right) report("out_right", out_right, want.out_right);
          if (clipped !== want.clipped) report("clipped", clipped, want.clipped);
        end
      end
      // voice transfer in
      if (push && !full)
        take_item();
    end
    pending = frames_due.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the mixer testbench: clock, reset, stimulus, receiver, watchdog and verdict.
module testbench;
  import vglm_pkg::*;

  localparam int ITEMS_PER_PHASE = 240;
  localparam int OVERLOAD_LEN    = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_AFTER      = 300;
  localparam int SETTLE          = 10;
  localparam int WATCH_LIMIT     = 3000;
  localparam logic [2:0] GAIN_ADDR  = 3'(4 * int'(REG_OUTPUT_GAIN));
  localparam logic [2:0] SPARE_ADDR = 3'(4 * (int'(REG_OUTPUT_GAIN) + 1));

  typedef struct {
    logic [VOICE_W-1:0]         voice;
    logic signed [SAMPLE_W-1:0] sl;
    logic signed [SAMPLE_W-1:0] sr;
    logic [GAIN_W-1:0]          gl;
    logic [GAIN_W-1:0]          gr;
    logic [ALPHA_W-1:0]         a;
    logic                       restart;
    logic                       skip;
    logic                       fend;
  } voice_item_t;

  logic                       clk;
  logic                       rst;
  logic                       push;
  logic                       full;
  logic [VOICE_W-1:0]         voice;
  logic signed [SAMPLE_W-1:0] sample_left;
  logic signed [SAMPLE_W-1:0] sample_right;
  logic [GAIN_W-1:0]          gain_left;
  logic [GAIN_W-1:0]          gain_right;
  logic [ALPHA_W-1:0]         alpha;
  logic                       restart;
  logic                       skip;
  logic                       frame_end;
  logic                       empty;
  logic                       pop;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       clipped;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  int errors;
  int pending;
  int frames_seen;
  int clips_seen;

  int items_sent = 0;
  int gain_writes = 0;
  int idle_cycles = 0;
  int rx_gap = 0;
  bit rx_hold = 1'b0;
  bit rx_steady = 1'b0;
  bit tx_steady = 1'b0;

  voice_gain_lowpass_mixer u_top (.*);

  mixer_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop the run if the block stops moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d frames pending", idle_cycles, pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Frame receiver: random gaps between pops, held off while rx_hold is up
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold || rx_gap > 0) begin
        pop <= 1'b0;
        if (!rx_hold) rx_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if ($urandom_range(0, 31) == 0) rx_steady <= ~rx_steady;
      rx_gap <= rx_steady ? 0 : $urandom_range(0, 15);
    end
  end

  // Long receiver hold-off so the block fills and pushes back
  initial begin
    wait (items_sent >= HOLD_AFTER);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic voice_item_t make(int v, int sl, int sr, int gl, int gr, int a,
                                       bit rs, bit sk, bit fe);
    voice_item_t it;
    it.voice = v[VOICE_W-1:0];
    it.sl = sl[SAMPLE_W-1:0];
    it.sr = sr[SAMPLE_W-1:0];
    it.gl = gl[GAIN_W-1:0];
    it.gr = gr[GAIN_W-1:0];
    it.a = a[ALPHA_W-1:0];
    it.restart = rs;
    it.skip = sk;
    it.fend = fe;
    return it;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 11))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rand_gain();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 65535;
      2: return 16384;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rand_alpha();
    case ($urandom_range(0, 7))
      0: return $urandom_range(32730, 32770);
      1: return $urandom_range(0, 65535);
      2: return $urandom_range(0, 64);
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  // Offer one voice item after a random gap, hold until transfer
  task automatic offer(voice_item_t it);
    int gap;
    gap = (tx_steady || rx_hold) ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    voice <= it.voice;
    sample_left <= it.sl;
    sample_right <= it.sr;
    gain_left <= it.gl;
    gain_right <= it.gr;
    alpha <= it.a;
    restart <= it.restart;
    skip <= it.skip;
    frame_end <= it.fend;
    do @(posedge clk); while (full);
    items_sent++;
    if ($urandom_range(0, 63) == 0) tx_steady = ~tx_steady;
  endtask

  // Drop push and wait until every expected frame has come out
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic reg_access(bit wr, logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_gain(logic [GAIN_W-1:0] g);
    reg_access(1'b1, GAIN_ADDR, {16'd0, g});
    reg_access(1'b0, GAIN_ADDR, '0);
    gain_writes++;
  endtask

  // Well-formed frames of mostly consecutive voices, with some stray voices
  task automatic random_frames(int count);
    int left;
    int len;
    int base;
    int v;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 16);
      if (len > left) len = left;
      base = $urandom_range(0, 15);
      for (int k = 0; k < len; k++) begin
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : (base + k) % 16;
        offer(make(v, rand_sample(), rand_sample(), rand_gain(), rand_gain(), rand_alpha(),
                   $urandom_range(0, 15) == 0, $urandom_range(0, 11) == 0, k == len - 1));
      end
      left -= len;
    end
  endtask

  // Drive both frame sums into the accumulator limits, opposite signs
  task automatic overload_frame();
    for (int k = 0; k < OVERLOAD_LEN; k++)
      offer(make(k % 16, 32767, -32768, 65535, 65535, 32768, 0, 0, k == OVERLOAD_LEN - 1));
  endtask

  initial begin
    logic [GAIN_W-1:0] gains [7];
    rst = 1'b1;
    push = 1'b0;
    voice = '0;
    sample_left = '0;
    sample_right = '0;
    gain_left = '0;
    gain_right = '0;
    alpha = '0;
    restart = 1'b0;
    skip = 1'b0;
    frame_end = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed items at the reset output gain
    offer(make(0, 32767, -32768, 65535, 65535, 32768, 0, 0, 1));
    offer(make(1, -32768, 32767, 16384, 16384, 0, 0, 0, 0));
    offer(make(1, 1000, -1000, 16384, 16384, 16384, 0, 0, 0));
    offer(make(1, 1000, -1000, 16384, 16384, 32735, 0, 0, 1));
    offer(make(2, 12345, -12345, 16384, 16384, 32736, 0, 0, 0));
    offer(make(3, -1, 1, 65535, 65535, 65535, 0, 0, 0));
    offer(make(1, 0, 0, 0, 0, 8192, 0, 0, 1));
    offer(make(1, 500, 500, 16384, 16384, 8192, 1, 1, 0));
    offer(make(1, 500, 500, 16384, 16384, 8192, 0, 0, 1));
    offer(make(15, 32767, 32767, 0, 65535, 100, 0, 0, 0));
    offer(make(15, -32768, -32768, 65535, 0, 100, 1, 0, 0));
    offer(make(4, 32767, 32767, 65535, 65535, 32768, 0, 1, 1));
    offer(make(5, 20000, -20000, 32768, 32768, 32768, 0, 0, 0));
    offer(make(6, 20000, -20000, 32768, 32768, 32768, 0, 0, 1));
    offer(make(0, 0, 0, 0, 0, 0, 0, 1, 1));
    for (int k = 0; k < 4; k++)
      offer(make(7, -32768, -32768, 65535, 65535, 1, 0, 0, 1));
    offer(make(8, 'h5555, 'hAAAA, 'hAAAA, 'h5555, 'h5555, 0, 0, 1));
    offer(make(9, 'hAAAA, 'h5555, 'h5555, 'hAAAA, 'hAAAA, 1, 0, 1));
    settle();

    // Random phases under a range of output gains
    gains[0] = 16'hffff;
    gains[1] = 16'h0000;
    gains[2] = 16'h0001;
    gains[3] = OUT_GAIN_RESET;
    gains[4] = 16'($urandom_range(0, 65535));
    gains[5] = 16'($urandom_range(0, 65535));
    gains[6] = 16'h2000;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) reg_access(1'b1, SPARE_ADDR, $urandom);
      set_gain(gains[ph]);
      if (ph == 3) overload_frame();
      random_frames(ITEMS_PER_PHASE);
      settle();
    end

    $display("run covered %0d voice items over %0d output gain settings", items_sent,
             gain_writes + 1);
    $display("%0d frames checked, %0d of them clipped, %0d mismatches", frames_seen, clips_seen,
             errors);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/vglm_pkg.sv
hdl/vglm_fifo.sv
hdl/vglm_front.sv
hdl/vglm_back.sv
hdl/voice_gain_lowpass_mixer.sv
test/mixer_checker.sv
test/testbench.sv
